// ----- rtl/mscs_pkg.sv -----
// Package: shared types and constants for the moment syndrome single corrector.
`timescale 1ns / 1ps

package mscs_pkg;

    localparam int unsigned POS_W    = 10;  // position counter width
    localparam int unsigned ACC_W    = 32;  // moment sum width
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned W_W      = 11;  // weight w = pos + 1, up to 1024
    localparam int unsigned SQ_W     = 21;  // w^2, up to 2^20
    localparam int unsigned DIV_STEPS = 32; // one quotient bit per step
    localparam int unsigned DCNT_W   = 5;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_CHECK,
        ST_DIVIDE,
        ST_SQUARE,
        ST_SCALE,
        ST_CUBE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic acc_en;      // byte transfer: update moment sums
        logic capture;     // last byte: latch residuals, clear sums
        logic div_load;
        logic div_step;
        logic sq_load;
        logic scale_load;
        logic cube_load;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic d_ok;        // plain residual is a usable delta
        logic div_last;    // divider on its final step
        logic out_free;    // output register can take a result
    } status_t;

endpackage

// ----- rtl/mscs_in_if.sv -----
// Interface: input byte channel with valid/ready handshake.
`timescale 1ns / 1ps

interface mscs_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        last;
    logic [31:0] ref_sum_plain;
    logic [31:0] ref_sum_linear;
    logic [31:0] ref_sum_square;
    logic [31:0] ref_sum_cube;

    modport source (
        output valid, data_byte, last,
               ref_sum_plain, ref_sum_linear, ref_sum_square, ref_sum_cube,
        input  ready
    );
    modport sink (
        input  valid, data_byte, last,
               ref_sum_plain, ref_sum_linear, ref_sum_square, ref_sum_cube,
        output ready
    );
endinterface

// ----- rtl/mscs_out_if.sv -----
// Interface: result channel with valid/ready handshake.
`timescale 1ns / 1ps

interface mscs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] residual_plain;
    logic [31:0] residual_linear;
    logic [31:0] residual_square;
    logic [31:0] residual_cube;
    logic        error_detected;
    logic        correctable;
    logic [9:0]  error_position;
    logic [7:0]  correction_value;

    modport source (
        output valid, residual_plain, residual_linear, residual_square, residual_cube,
               error_detected, correctable, error_position, correction_value,
        input  ready
    );
    modport sink (
        input  valid, residual_plain, residual_linear, residual_square, residual_cube,
               error_detected, correctable, error_position, correction_value,
        output ready
    );
endinterface

// ----- rtl/moment_syndrome_single_corrector.sv -----
// Top level: moment syndrome checker with single-byte error locator.
//
// Channels: in_ch (sink) carries one byte per transfer, in position order,
// with last marking the final byte; the four reference sums are sampled on
// that last transfer only. out_ch (source) carries one result per block:
// the four residuals (computed minus reference, mod 2^32), error_detected,
// correctable, the one-based error_position and the correction_value.
// cfg_we/cfg_wdata write check_high_moments (reset 1); write only while idle.
//
// Throughput: one byte per cycle inside a block; the moment sums use
// incrementally tracked powers w, w^2, w^3 so no byte stalls the intake.
// After the last byte the intake pauses for the locator: a check state,
// the bit-serial divider, 3 multiply steps (square, scale, cube) and a
// finish state that loads the result register once it is free; intake
// resumes after that load. An unusable delta skips the divider and
// multiplies and goes from the check state straight to finish.
// Reset: sums, position and result valid clear; check_high_moments = 1.
// Stall: a result waits in the output register; bytes of the next block
// are still taken, and the next block's result waits for the register.
`timescale 1ns / 1ps

module moment_syndrome_single_corrector #(
    parameter int unsigned BLOCK_BYTES = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    mscs_in_if.sink     in_ch,
    mscs_out_if.source  out_ch
);

    mscs_pkg::cmd_t    cmd;
    mscs_pkg::status_t status;

    // sequencer: intake, capture, divide, multiply, finish
    mscs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_last  (in_ch.last),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // sums, residuals, divider, checks and result register
    mscs_datapath #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .cmd              (cmd),
        .status           (status),
        .data_byte        (in_ch.data_byte),
        .ref_sum_plain    (in_ch.ref_sum_plain),
        .ref_sum_linear   (in_ch.ref_sum_linear),
        .ref_sum_square   (in_ch.ref_sum_square),
        .ref_sum_cube     (in_ch.ref_sum_cube),
        .out_ready        (out_ch.ready),
        .out_valid        (out_ch.valid),
        .residual_plain   (out_ch.residual_plain),
        .residual_linear  (out_ch.residual_linear),
        .residual_square  (out_ch.residual_square),
        .residual_cube    (out_ch.residual_cube),
        .error_detected   (out_ch.error_detected),
        .correctable      (out_ch.correctable),
        .error_position   (out_ch.error_position),
        .correction_value (out_ch.correction_value)
    );

endmodule

// ----- rtl/mscs_divider.sv -----
// Divider: restoring 32-bit by 8-bit magnitude divider, one quotient bit per cycle while step is high.
`timescale 1ns / 1ps

module mscs_divider (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  logic                            step,
    input  logic [mscs_pkg::ACC_W-1:0]      dividend,
    input  logic [mscs_pkg::BYTE_W-1:0]     divisor,
    output logic [mscs_pkg::ACC_W-1:0]      quotient,
    output logic [mscs_pkg::BYTE_W-1:0]     remainder,
    output logic                            last_step
);

    logic [mscs_pkg::ACC_W-1:0]  quot_reg, quot_next;
    logic [mscs_pkg::BYTE_W-1:0] rem_reg, rem_next;
    logic [mscs_pkg::BYTE_W-1:0] div_reg, div_next;
    logic [mscs_pkg::DCNT_W-1:0] cnt_reg, cnt_next;
    logic [mscs_pkg::BYTE_W:0]   rem_sh;
    logic [mscs_pkg::BYTE_W:0]   rem_sub;
    logic                        fits;

    assign rem_sh  = {rem_reg, quot_reg[mscs_pkg::ACC_W-1]};
    assign fits    = rem_sh >= {1'b0, div_reg};
    assign rem_sub = rem_sh - {1'b0, div_reg};

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        if (load)
        begin
            quot_next = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = '0;
        end
        else if (step)
        begin
            quot_next = {quot_reg[mscs_pkg::ACC_W-2:0], fits};
            rem_next  = fits ? rem_sub[mscs_pkg::BYTE_W-1:0]
                             : rem_sh[mscs_pkg::BYTE_W-1:0];
            cnt_next  = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end

    assign quotient  = quot_reg;
    assign remainder = rem_reg;
    assign last_step = cnt_reg == mscs_pkg::DCNT_W'(mscs_pkg::DIV_STEPS - 1);

endmodule

// ----- rtl/mscs_datapath.sv -----
// Datapath: moment sums, residual capture, locator arithmetic and result register.
`timescale 1ns / 1ps

module mscs_datapath #(
    parameter int unsigned BLOCK_BYTES = 512
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata,
    input  mscs_pkg::cmd_t        cmd,
    output mscs_pkg::status_t     status,
    input  logic [7:0]            data_byte,
    input  logic [31:0]           ref_sum_plain,
    input  logic [31:0]           ref_sum_linear,
    input  logic [31:0]           ref_sum_square,
    input  logic [31:0]           ref_sum_cube,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [31:0]           residual_plain,
    output logic [31:0]           residual_linear,
    output logic [31:0]           residual_square,
    output logic [31:0]           residual_cube,
    output logic                  error_detected,
    output logic                  correctable,
    output logic [9:0]            error_position,
    output logic [7:0]            correction_value
);

    localparam int unsigned QW = $clog2(BLOCK_BYTES + 1);
    localparam int unsigned DW = 2 * QW + 10;
    localparam int unsigned CW = (DW > 33) ? DW : 33;
    localparam int unsigned AW = mscs_pkg::ACC_W;

    // ---------------- configuration ----------------
    logic gate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gate_reg <= 1'b1;
        else if (cfg_we)
            gate_reg <= cfg_wdata;
    end

    // ---------------- moment sums ----------------
    logic [mscs_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [mscs_pkg::SQ_W-1:0]  sq_reg, sq_next;     // w^2 for w = pos + 1
    logic [AW-1:0]              cube_reg, cube_next; // w^3 mod 2^32
    logic [AW-1:0] acc_plain_reg, acc_linear_reg, acc_square_reg, acc_cube_reg;
    logic [AW-1:0] sum_plain, sum_linear, sum_square, sum_cube;
    logic [mscs_pkg::W_W-1:0]   w;
    logic                       restart;

    assign w = {1'b0, pos_reg} + 1'b1;
    assign restart = cmd.capture || (pos_reg == mscs_pkg::POS_MAX);

    assign sum_plain  = acc_plain_reg  + AW'(data_byte);
    assign sum_linear = acc_linear_reg + AW'(data_byte) * AW'(w);
    assign sum_square = acc_square_reg + AW'(data_byte) * AW'(sq_reg);
    assign sum_cube   = acc_cube_reg   + AW'(data_byte) * cube_reg;

    always_comb
    begin
        pos_next  = pos_reg + 1'b1;
        sq_next   = sq_reg + mscs_pkg::SQ_W'({w, 1'b0}) + 1'b1;
        cube_next = cube_reg + AW'(sq_reg) * AW'(3) + AW'(w) * AW'(3) + AW'(1);
        if (restart)
        begin
            pos_next  = '0;
            sq_next   = mscs_pkg::SQ_W'(1);
            cube_next = AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            sq_reg         <= mscs_pkg::SQ_W'(1);
            cube_reg       <= AW'(1);
            acc_plain_reg  <= '0;
            acc_linear_reg <= '0;
            acc_square_reg <= '0;
            acc_cube_reg   <= '0;
        end
        else if (cmd.acc_en)
        begin
            pos_reg  <= pos_next;
            sq_reg   <= sq_next;
            cube_reg <= cube_next;
            if (cmd.capture)
            begin
                acc_plain_reg  <= '0;
                acc_linear_reg <= '0;
                acc_square_reg <= '0;
                acc_cube_reg   <= '0;
            end
            else
            begin
                acc_plain_reg  <= sum_plain;
                acc_linear_reg <= sum_linear;
                acc_square_reg <= sum_square;
                acc_cube_reg   <= sum_cube;
            end
        end
    end

    // ---------------- residuals ----------------
    logic [AW-1:0] res_plain_reg, res_linear_reg, res_square_reg, res_cube_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            res_plain_reg  <= sum_plain  - ref_sum_plain;
            res_linear_reg <= sum_linear - ref_sum_linear;
            res_square_reg <= sum_square - ref_sum_square;
            res_cube_reg   <= sum_cube   - ref_sum_cube;
        end
    end

    // delta in 1..255 or -255..-1
    logic          d_neg, lin_neg, d_ok;
    logic [7:0]    d_mag;
    logic [AW-1:0] lin_mag;
    logic [AW-1:0] plain_neg;

    assign d_neg     = res_plain_reg[AW-1];
    assign plain_neg = '0 - res_plain_reg;
    assign d_ok      = (res_plain_reg[AW-1:8] == '0 && res_plain_reg[7:0] != '0)
                    || (res_plain_reg[AW-1:8] == '1 && res_plain_reg[7:0] != '0);
    assign d_mag     = d_neg ? plain_neg[7:0] : res_plain_reg[7:0];
    assign lin_neg   = res_linear_reg[AW-1];
    assign lin_mag   = lin_neg ? ('0 - res_linear_reg) : res_linear_reg;

    // ---------------- divider ----------------
    logic [AW-1:0] quot;
    logic [7:0]    rem;
    logic          div_last;

    mscs_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (cmd.div_load),
        .step      (cmd.div_step),
        .dividend  (lin_mag),
        .divisor   (d_mag),
        .quotient  (quot),
        .remainder (rem),
        .last_step (div_last)
    );

    // ---------------- high moment checks ----------------
    logic [QW-1:0]          q_n;
    logic [2*QW-1:0]        q2_reg;
    logic signed [DW-1:0]   dq2_reg;
    logic [AW-1:0]          dq3_reg;
    logic signed [8:0]      d9;
    logic signed [2*QW:0]   q2s;
    logic signed [CW-1:0]   dq2_ext, r2_ext;
    logic [AW-1:0]          dq2_lo, q_ext;

    assign q_n     = quot[QW-1:0];
    assign d9      = $signed(res_plain_reg[8:0]);
    assign q2s     = $signed({1'b0, q2_reg});
    assign dq2_ext = CW'(dq2_reg);
    assign r2_ext  = CW'($signed(res_square_reg));
    assign dq2_lo  = dq2_ext[AW-1:0];
    assign q_ext   = AW'(q_n);

    always_ff @(posedge clk)
    begin
        if (cmd.sq_load)
            q2_reg <= q_n * q_n;
        if (cmd.scale_load)
            dq2_reg <= d9 * q2s;
        if (cmd.cube_load)
            dq3_reg <= dq2_lo * q_ext;
    end

    // ---------------- verdict ----------------
    logic quot_ok, high_ok, fix_ok;

    assign quot_ok = (quot != '0) && (quot <= AW'(BLOCK_BYTES)) && (lin_neg == d_neg);
    assign high_ok = (dq2_ext == r2_ext) && (dq3_reg == res_cube_reg);
    assign fix_ok  = d_ok && (rem == '0) && quot_ok && (!gate_reg || high_ok);

    // ---------------- result register ----------------
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            residual_plain   <= res_plain_reg;
            residual_linear  <= res_linear_reg;
            residual_square  <= res_square_reg;
            residual_cube    <= res_cube_reg;
            error_detected   <= (res_plain_reg | res_linear_reg | res_square_reg
                                 | res_cube_reg) != '0;
            correctable      <= fix_ok;
            error_position   <= fix_ok ? quot[9:0] : '0;
            correction_value <= fix_ok ? res_plain_reg[7:0] : '0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status.d_ok     = d_ok;
    assign status.div_last = div_last;
    assign status.out_free = !out_valid_reg || out_ready;

endmodule

// ----- rtl/mscs_ctrl.sv -----
// Controller: sequences byte intake, residual capture and the locator steps.
`timescale 1ns / 1ps

module mscs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_last,
    output logic               in_ready,
    input  mscs_pkg::status_t  status,
    output mscs_pkg::cmd_t     cmd
);

    mscs_pkg::state_t state_reg, state_next;
    logic accept;

    assign accept = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mscs_pkg::ST_ACCUM:
                if (accept && in_last)
                    state_next = mscs_pkg::ST_CHECK;
            mscs_pkg::ST_CHECK:
                state_next = status.d_ok ? mscs_pkg::ST_DIVIDE : mscs_pkg::ST_FINISH;
            mscs_pkg::ST_DIVIDE:
                if (status.div_last)
                    state_next = mscs_pkg::ST_SQUARE;
            mscs_pkg::ST_SQUARE:
                state_next = mscs_pkg::ST_SCALE;
            mscs_pkg::ST_SCALE:
                state_next = mscs_pkg::ST_CUBE;
            mscs_pkg::ST_CUBE:
                state_next = mscs_pkg::ST_FINISH;
            mscs_pkg::ST_FINISH:
                if (status.out_free)
                    state_next = mscs_pkg::ST_ACCUM;
            default:
                state_next = mscs_pkg::ST_ACCUM;
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = '0;
        case (state_reg)
            mscs_pkg::ST_ACCUM:
            begin
                in_ready    = 1'b1;
                cmd.acc_en  = accept;
                cmd.capture = accept && in_last;
            end
            mscs_pkg::ST_CHECK:
                cmd.div_load = status.d_ok;
            mscs_pkg::ST_DIVIDE:
                cmd.div_step = 1'b1;
            mscs_pkg::ST_SQUARE:
                cmd.sq_load = 1'b1;
            mscs_pkg::ST_SCALE:
                cmd.scale_load = 1'b1;
            mscs_pkg::ST_CUBE:
                cmd.cube_load = 1'b1;
            mscs_pkg::ST_FINISH:
                cmd.out_load = status.out_free;
            default:
                cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mscs_pkg::ST_ACCUM;
        else
            state_reg <= state_next;
    end

    // result only loaded when the output register can take it
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over a pending transfer");

    // last byte always starts the locator
    a_capture_check: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == mscs_pkg::ST_CHECK)
        else $error("capture not followed by check");

    // unusable delta skips the divider
    a_skip_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mscs_pkg::ST_CHECK && !status.d_ok) |=> state_reg == mscs_pkg::ST_FINISH)
        else $error("divider run on invalid delta");

    // no byte intake while the locator runs
    a_no_intake: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != mscs_pkg::ST_ACCUM) |-> !cmd.acc_en)
        else $error("byte taken during locator");

endmodule
